>>> hw/rtl/som_ns_pkg.sv
`timescale 1ns / 1ps

package som_ns_pkg;

    // Default sizes of the neighbourhood table and of the map grid.
    localparam int MAX_NEIGHBORS_DEF = 64;
    localparam int MAX_GRID_SIDE_DEF = 256;

    // Widths of the configuration port and of the grid side, unit count and neighbour count registers.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 17;
    localparam int SIDE_W      = 9;
    localparam int UNITS_W     = 17;
    localparam int COUNT_W     = 7;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_GRID_WIDTH     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GRID_HEIGHT    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNIT_COUNT     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_WRAP_ENABLE    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_NEIGHBOR_COUNT = 3'd4;

    // Largest unit count that is honoured.
    localparam logic [UNITS_W-1:0] UNITS_MAX = 17'd65536;

    // Input item modes.
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_APPLY = 1'b1;

    // Input item.
    typedef struct packed {
        logic               mode;
        logic [5:0]         entry_slot;
        logic signed [7:0]  offset_x;
        logic signed [7:0]  offset_y;
        logic signed [15:0] entry_activation;
        logic [7:0]         winner_x;
        logic [7:0]         winner_y;
    } in_item_t;

    // Result item.
    typedef struct packed {
        logic [15:0]        unit_index;
        logic signed [15:0] unit_activation;
        logic               hit;
        logic               last;
    } out_item_t;

    // One neighbourhood table word: activation over row and column offsets.
    typedef struct packed {
        logic signed [15:0] activation;
        logic signed [7:0]  offset_y;
        logic signed [7:0]  offset_x;
    } entry_t;

    // Command handed from the front end to the back end.
    typedef enum logic {
        CMD_LOAD,
        CMD_APPLY
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [5:0] slot;
        entry_t     entry;
        logic [7:0] winner_x;
        logic [7:0] winner_y;
    } cmd_t;

    // Configuration register file contents.
    typedef struct packed {
        logic [SIDE_W-1:0]  grid_width;
        logic [SIDE_W-1:0]  grid_height;
        logic [UNITS_W-1:0] unit_count;
        logic               wrap_enable;
        logic [COUNT_W-1:0] neighbor_count;
    } cfg_t;

endpackage

>>> hw/rtl/som_ns_ram.sv
`timescale 1ns / 1ps

module som_ns_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Single write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/som_ns_queue.sv
`timescale 1ns / 1ps

module som_ns_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  som_ns_pkg::cmd_t  push_cmd,
    input  logic              pop,
    output som_ns_pkg::cmd_t  pop_cmd,
    output logic              full,
    output logic              empty
);

    som_ns_pkg::cmd_t slot_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       fill_reg;
    logic [1:0]       fill_next;

    // Pointer and fill level update for a two-entry command queue.
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Command storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign pop_cmd = slot_reg[rd_ptr_reg];
    assign full    = fill_reg[1];
    assign empty   = (fill_reg == 2'd0);

endmodule

>>> hw/rtl/som_ns_front.sv
`timescale 1ns / 1ps

module som_ns_front #(
    parameter int MAX_NEIGHBORS = som_ns_pkg::MAX_NEIGHBORS_DEF
) (
    input  logic                            in_valid,
    output logic                            in_stall,
    input  som_ns_pkg::in_item_t            in_data,
    input  logic [som_ns_pkg::COUNT_W-1:0]  neighbor_count,
    input  logic                            q_full,
    output logic                            push,
    output som_ns_pkg::cmd_t                push_cmd
);

    logic accept;
    logic keep;

    // An item is taken whenever the command queue has room.
    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    // Loads into slots past the table and applies over an empty table are
    // dropped here; everything else becomes a command for the back end.
    always_comb
    begin
        push_cmd.slot     = in_data.entry_slot;
        push_cmd.entry    = '{activation: in_data.entry_activation,
                              offset_y:   in_data.offset_y,
                              offset_x:   in_data.offset_x};
        push_cmd.winner_x = in_data.winner_x;
        push_cmd.winner_y = in_data.winner_y;
        if (in_data.mode == som_ns_pkg::MODE_LOAD)
        begin
            push_cmd.kind = som_ns_pkg::CMD_LOAD;
            keep = ({1'b0, in_data.entry_slot} < 7'(MAX_NEIGHBORS));
        end
        else
        begin
            push_cmd.kind = som_ns_pkg::CMD_APPLY;
            keep = (neighbor_count != '0);
        end
    end

    assign push = accept && keep;

endmodule

>>> hw/rtl/som_ns_back.sv
`timescale 1ns / 1ps

module som_ns_back #(
    parameter int MAX_NEIGHBORS = som_ns_pkg::MAX_NEIGHBORS_DEF,
    parameter int MAX_GRID_SIDE = som_ns_pkg::MAX_GRID_SIDE_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  som_ns_pkg::cfg_t      cfg,
    input  logic                  q_empty,
    input  som_ns_pkg::cmd_t      q_cmd,
    output logic                  q_pop,
    output logic                  out_valid,
    input  logic                  out_stall,
    output som_ns_pkg::out_item_t out_data
);

    localparam int AW       = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
    localparam int CW       = $clog2(MAX_NEIGHBORS + 1);
    localparam int SW       = som_ns_pkg::SIDE_W;
    localparam int SIDE_CAP = (MAX_GRID_SIDE > 511) ? 511 : MAX_GRID_SIDE;
    localparam int IDX_W    = 2 * SW + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SETUP,
        S_DIV,
        S_MUL,
        S_OUT
    } state_t;

    // Per-axis preparation: miss flag, sign and magnitude for the divider.
    typedef struct packed {
        logic          miss;
        logic          neg;
        logic [SW-1:0] mag;
    } axis_t;

    function automatic axis_t axis_prep(input logic signed [SW:0] coord,
                                        input logic [SW-1:0] side,
                                        input logic wrap);
        axis_t a;
        logic  in_range;
        in_range = !coord[SW] && (coord[SW-1:0] < side);
        a.neg    = coord[SW];
        a.mag    = coord[SW] ? SW'(-coord) : coord[SW-1:0];
        a.miss   = (side == '0) || (!in_range && !wrap);
        return a;
    endfunction

    // One restoring step of the remainder.
    function automatic logic [SW-1:0] mod_step(input logic [SW-1:0] rem,
                                               input logic bit_in,
                                               input logic [SW-1:0] side);
        logic [SW:0] t;
        t = {rem, bit_in};
        if (t >= {1'b0, side})
        begin
            t = t - {1'b0, side};
        end
        return t[SW-1:0];
    endfunction

    // Negative coordinates wrap from the top of the side.
    function automatic logic [SW-1:0] fold(input logic [SW-1:0] rem,
                                           input logic neg,
                                           input logic [SW-1:0] side);
        return (neg && rem != '0) ? side - rem : rem;
    endfunction

    state_t                       state_reg;
    logic [CW-1:0]                cnt_reg;
    logic [CW-1:0]                n_reg;
    logic [7:0]                   wx_reg;
    logic [7:0]                   wy_reg;
    logic signed [15:0]           act_reg;
    axis_t                        ax_reg;
    axis_t                        ay_reg;
    logic [SW-1:0]                rem_x_reg;
    logic [SW-1:0]                rem_y_reg;
    logic [3:0]                   step_reg;
    logic [IDX_W-1:0]             idx_reg;
    logic                         out_valid_reg;
    som_ns_pkg::out_item_t        out_data_reg;

    logic [SW-1:0]                side_x;
    logic [SW-1:0]                side_y;
    logic [som_ns_pkg::UNITS_W-1:0] units;
    logic [CW-1:0]                n_sat;
    logic                         ram_we;
    logic                         ram_re;
    logic [31:0]                  ram_rdata;
    som_ns_pkg::entry_t           rd_entry;
    logic signed [SW:0]           cx_raw;
    logic signed [SW:0]           cy_raw;
    axis_t                        ax_next;
    axis_t                        ay_next;
    logic [SW-1:0]                cx;
    logic [SW-1:0]                cy;
    logic [2*SW-1:0]              prod;
    logic [IDX_W-1:0]             idx_next;
    logic                         out_free;
    logic                         out_load;
    logic                         is_last;
    logic                         hit;

    // Saturated configuration values.
    assign side_x = (cfg.grid_width > SW'(SIDE_CAP)) ? SW'(SIDE_CAP) : cfg.grid_width;
    assign side_y = (cfg.grid_height > SW'(SIDE_CAP)) ? SW'(SIDE_CAP) : cfg.grid_height;
    assign units  = (cfg.unit_count > som_ns_pkg::UNITS_MAX) ? som_ns_pkg::UNITS_MAX
                                                             : cfg.unit_count;
    assign n_sat  = (cfg.neighbor_count > 7'(MAX_NEIGHBORS)) ? CW'(MAX_NEIGHBORS)
                                                             : CW'(cfg.neighbor_count);

    // Table access: loads write from idle, applies read one entry each pass.
    assign q_pop  = (state_reg == S_IDLE) && !q_empty;
    assign ram_we = q_pop && (q_cmd.kind == som_ns_pkg::CMD_LOAD);
    assign ram_re = (state_reg == S_READ);

    som_ns_ram #(
        .WIDTH (32),
        .DEPTH (MAX_NEIGHBORS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (q_cmd.slot[AW-1:0]),
        .wdata (q_cmd.entry),
        .re    (ram_re),
        .raddr (cnt_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign rd_entry = som_ns_pkg::entry_t'(ram_rdata);

    // Coordinates of the entry around the winner and their classification.
    assign cx_raw  = $signed({2'b00, wx_reg} + {{2{rd_entry.offset_x[7]}}, rd_entry.offset_x});
    assign cy_raw  = $signed({2'b00, wy_reg} + {{2{rd_entry.offset_y[7]}}, rd_entry.offset_y});
    assign ax_next = axis_prep(cx_raw, side_x, cfg.wrap_enable);
    assign ay_next = axis_prep(cy_raw, side_y, cfg.wrap_enable);

    // Linear index from the reduced coordinates.
    assign cx       = fold(rem_x_reg, ax_reg.neg, side_x);
    assign cy       = fold(rem_y_reg, ay_reg.neg, side_y);
    assign prod     = cy * side_x;
    assign idx_next = {1'b0, prod} + {{(IDX_W - SW){1'b0}}, cx};

    // Result assembly.
    assign hit      = !ax_reg.miss && !ay_reg.miss
                      && (idx_reg < {{(IDX_W - som_ns_pkg::UNITS_W){1'b0}}, units});
    assign is_last  = ((cnt_reg + CW'(1)) == n_reg);
    assign out_free = !out_valid_reg || !out_stall;
    assign out_load = (state_reg == S_OUT) && out_free;

    // Entry sequencer and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            n_reg         <= '0;
            wx_reg        <= '0;
            wy_reg        <= '0;
            act_reg       <= '0;
            ax_reg        <= '0;
            ay_reg        <= '0;
            rem_x_reg     <= '0;
            rem_y_reg     <= '0;
            step_reg      <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (q_pop && q_cmd.kind == som_ns_pkg::CMD_APPLY)
                    begin
                        wx_reg    <= q_cmd.winner_x;
                        wy_reg    <= q_cmd.winner_y;
                        n_reg     <= n_sat;
                        cnt_reg   <= '0;
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    state_reg <= S_SETUP;
                end
                S_SETUP:
                begin
                    ax_reg    <= ax_next;
                    ay_reg    <= ay_next;
                    act_reg   <= rd_entry.activation;
                    rem_x_reg <= '0;
                    rem_y_reg <= '0;
                    step_reg  <= 4'(SW - 1);
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    // One quotient bit per cycle on both axes, most significant first.
                    rem_x_reg     <= mod_step(rem_x_reg, ax_reg.mag[SW-1], side_x);
                    rem_y_reg     <= mod_step(rem_y_reg, ay_reg.mag[SW-1], side_y);
                    ax_reg.mag    <= {ax_reg.mag[SW-2:0], 1'b0};
                    ay_reg.mag    <= {ay_reg.mag[SW-2:0], 1'b0};
                    step_reg      <= step_reg - 4'd1;
                    if (step_reg == 4'd0)
                    begin
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    idx_reg   <= idx_next;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg                <= 1'b1;
                        out_data_reg.unit_index      <= hit ? idx_reg[15:0] : 16'd0;
                        out_data_reg.unit_activation <= hit ? act_reg : 16'sd0;
                        out_data_reg.hit             <= hit;
                        out_data_reg.last            <= is_last;
                        if (is_last)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            cnt_reg   <= cnt_reg + CW'(1);
                            state_reg <= S_READ;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTHESIS
    // The remainder loop always hands over to the index multiply.
    a_div_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && step_reg == 4'd0) |=> state_reg == S_MUL)
        else $error("divider did not hand over to the multiply");

    // The entry counter never runs past the number of entries in use.
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (cnt_reg < n_reg))
        else $error("entry counter beyond table size");

    // The result for the final entry ends the walk.
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && is_last) |=> (state_reg == S_IDLE && out_data_reg.last))
        else $error("walk continued after the final entry");
`endif

endmodule

>>> hw/rtl/som_neighborhood_scatter.sv
`timescale 1ns / 1ps

// SOM neighbourhood scatter.
// Input channel (in_valid, in_stall, in_data): an item is taken at a clock
// edge with in_valid high and in_stall low. A load item writes one
// neighbourhood table entry and gives no result; an apply item walks the
// first neighbor_count entries around the winner and gives one result each.
// Output channel (out_valid, out_stall, out_data): one result per edge with
// out_valid high and out_stall low; last marks the final entry of a walk.
// Items pass through a two-deep command queue, so the input keeps taking
// items while a walk is in progress until that queue is full.
// Each table entry passes through a table read, a setup step, the
// bit-serial remainder unit, the index multiply and the output register;
// the entries of a walk are handled one after another. A load is written
// to the table once the sequencer is idle and pops it from the queue.
// A stalled receiver holds the result in the output register and the walk
// pauses on the next entry. Reset clears the queue, the sequencer and the
// configuration registers (16 x 16 grid, 256 units, no wrap, no entries);
// the table contents are undefined until loaded.
// Configuration is written through cfg_we, cfg_index and cfg_data.

module som_neighborhood_scatter #(
    parameter int MAX_NEIGHBORS = som_ns_pkg::MAX_NEIGHBORS_DEF,
    parameter int MAX_GRID_SIDE = som_ns_pkg::MAX_GRID_SIDE_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  som_ns_pkg::in_item_t                in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output som_ns_pkg::out_item_t               out_data,
    input  logic                                cfg_we,
    input  logic [som_ns_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [som_ns_pkg::CFG_DATA_W-1:0]   cfg_data
);

    som_ns_pkg::cfg_t cfg_reg;
    logic             q_push;
    som_ns_pkg::cmd_t q_push_cmd;
    logic             q_pop;
    som_ns_pkg::cmd_t q_pop_cmd;
    logic             q_full;
    logic             q_empty;

    // Configuration register file.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.grid_width     <= 9'd16;
            cfg_reg.grid_height    <= 9'd16;
            cfg_reg.unit_count     <= 17'd256;
            cfg_reg.wrap_enable    <= 1'b0;
            cfg_reg.neighbor_count <= 7'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                som_ns_pkg::CFG_GRID_WIDTH:     cfg_reg.grid_width     <= cfg_data[8:0];
                som_ns_pkg::CFG_GRID_HEIGHT:    cfg_reg.grid_height    <= cfg_data[8:0];
                som_ns_pkg::CFG_UNIT_COUNT:     cfg_reg.unit_count     <= cfg_data[16:0];
                som_ns_pkg::CFG_WRAP_ENABLE:    cfg_reg.wrap_enable    <= cfg_data[0];
                som_ns_pkg::CFG_NEIGHBOR_COUNT: cfg_reg.neighbor_count <= cfg_data[6:0];
                default:
                begin
                end
            endcase
        end
    end

    // Front end: takes items and turns them into commands.
    som_ns_front #(
        .MAX_NEIGHBORS (MAX_NEIGHBORS)
    ) u_front (
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_data        (in_data),
        .neighbor_count (cfg_reg.neighbor_count),
        .q_full         (q_full),
        .push           (q_push),
        .push_cmd       (q_push_cmd)
    );

    // Command queue between the two halves.
    som_ns_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_push_cmd),
        .pop      (q_pop),
        .pop_cmd  (q_pop_cmd),
        .full     (q_full),
        .empty    (q_empty)
    );

    // Back end: table, remainder unit, index multiply and output register.
    som_ns_back #(
        .MAX_NEIGHBORS (MAX_NEIGHBORS),
        .MAX_GRID_SIDE (MAX_GRID_SIDE)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .q_cmd     (q_pop_cmd),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
